FILE: design/assert_macros.svh
// Assertion macros used by the manager design file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: design/lcm_pkg.sv
// Package for the lock and condition-variable manager: codes, widths, defaults.
// No dependencies.
package lcm_pkg;
  localparam int LocksDef = 16;
  localparam int CvarsDef = 16;
  localparam int ProcsDef = 16;
  localparam int UsersMax = 31;
  localparam int InW  = 16;
  localparam int OutW = 16;

  localparam logic [3:0] FN_LCREATE  = 4'd0;
  localparam logic [3:0] FN_ACQUIRE  = 4'd1;
  localparam logic [3:0] FN_RELEASE  = 4'd2;
  localparam logic [3:0] FN_CCREATE  = 4'd3;
  localparam logic [3:0] FN_WAIT     = 4'd4;
  localparam logic [3:0] FN_SIGNAL   = 4'd5;
  localparam logic [3:0] FN_BCAST    = 4'd6;
  localparam logic [3:0] FN_LRECLAIM = 4'd7;
  localparam logic [3:0] FN_CRECLAIM = 4'd8;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_BLOCK = 2'd1;
  localparam logic [1:0] ST_ERR   = 2'd2;
endpackage

FILE: design/lock_and_condvar_manager.sv
// Lock and condition-variable manager, top level.
// Depends on lcm_pkg and assert_macros.svh.
//
// channel  dir  handshake             payload
// in_      in   in_tvalid/in_tready   tdata: func, lock_index, cvar_index, proc_slot
// out_     out  out_tvalid/out_tready tdata: status,new_index,wake_valid,wake_proc; tlast
//
// Each request is accepted, then decoded; acquire, release, reclaim and errors then emit.
// Wait adds a cvar queue push; create scans the table for a free index before emitting.
// Signal pops one waiter, broadcast each; retry its recorded lock, send a wake for each grant.
// Reset clears all used/held flags and queue heads at once; no clearing pass.
// A stalled result holds the sequencer; in_tready needs idle and a free or draining output.
`include "assert_macros.svh"
module lock_and_condvar_manager #(
  parameter int LOCKS = lcm_pkg::LocksDef,
  parameter int CVARS = lcm_pkg::CvarsDef,
  parameter int PROCS = lcm_pkg::ProcsDef
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // func[3:0], lock_index[7:4], cvar_index[11:8], proc_slot[15:12]
  input  logic [lcm_pkg::InW-1:0] in_tdata,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // status[1:0], new_index[5:2], wake_valid[6], wake_proc[10:7], zero[15:11]
  output logic [lcm_pkg::OutW-1:0] out_tdata,
  output logic                    out_tlast
);
  import lcm_pkg::*;

  localparam int LW = (LOCKS > 1) ? $clog2(LOCKS) : 1;
  localparam int CW = (CVARS > 1) ? $clog2(CVARS) : 1;
  localparam int PW = $clog2(PROCS + 1);
  localparam int SW = (LOCKS > CVARS) ? $clog2(LOCKS + 1) : $clog2(CVARS + 1);
  localparam logic [PW-1:0] QEMPTY = PW'(PROCS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DEC   = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_POP   = 7'b0001000,
    S_RETRY = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [LOCKS-1:0] lused_r, lheld_r;
  logic [PW-1:0]    lowner_r [LOCKS];
  logic [4:0]       lusers_r [LOCKS];
  logic [PW-1:0]    lhead_r  [LOCKS];
  logic [PW-1:0]    ltail_r  [LOCKS];
  logic [CVARS-1:0] cused_r;
  logic [PW-1:0]    chead_r  [CVARS];
  logic [PW-1:0]    ctail_r  [CVARS];
  logic [PW-1:0]    plink_r  [PROCS];
  logic [LW-1:0]    pwant_r  [PROCS];

  logic [3:0]  func_r, lidx_r, cidx_r, pslot_r;
  logic [SW-1:0] scan_r;
  logic [PW-1:0] cnt_r;     // waiters taken by this broadcast
  logic [PW-1:0] wproc_r;   // popped waiter
  logic [PW-1:0] pend_r;    // granted waiter whose result is not sent yet
  logic          woke_any_r;
  logic [1:0]  o_st_r;
  logic [3:0]  o_idx_r, o_wp_r;
  logic        o_wv_r, o_last_r, o_valid_r;
  logic        fin_r;       // after this emit the request is finished

  assign in_tready  = (state_r == S_IDLE) && (!o_valid_r || out_tready);
  assign out_tvalid = o_valid_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {5'd0, o_wp_r, o_wv_r, o_idx_r, o_st_r};

  // range checks
  logic l_ok, c_ok, p_ok;
  assign l_ok = ({28'd0, lidx_r} < LOCKS);
  assign c_ok = ({28'd0, cidx_r} < CVARS);
  assign p_ok = ({28'd0, pslot_r} < PROCS);

  logic [LW-1:0] li;
  logic [CW-1:0] ci;
  logic [PW-1:0] pi;
  assign li = lidx_r[LW-1:0];
  assign ci = cidx_r[CW-1:0];
  assign pi = PW'(pslot_r);

  // popped waiter's lock
  logic [LW-1:0] wl;
  logic [PW-2:0] wsel;
  assign wsel = wproc_r[PW-2:0];
  assign wl = pwant_r[wsel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      lused_r   <= '0;
      lheld_r   <= '0;
      cused_r   <= '0;
      o_valid_r <= 1'b0;
      for (int i = 0; i < LOCKS; i++) begin
        lowner_r[i] <= '0;
        lusers_r[i] <= '0;
        lhead_r[i]  <= QEMPTY;
      end
      for (int i = 0; i < CVARS; i++) chead_r[i] <= QEMPTY;
    end else begin
      if (o_valid_r && out_tready) o_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            func_r  <= in_tdata[3:0];
            lidx_r  <= in_tdata[7:4];
            cidx_r  <= in_tdata[11:8];
            pslot_r <= in_tdata[15:12];
            scan_r  <= '0;
            cnt_r   <= '0;
            woke_any_r <= 1'b0;
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          o_st_r <= ST_ERR; o_idx_r <= '0; o_wv_r <= 1'b0; o_wp_r <= '0;
          o_last_r <= 1'b1; fin_r <= 1'b0;
          state_r <= S_EMIT;
          case (func_r)
            FN_LCREATE, FN_CCREATE: state_r <= S_SCAN;
            FN_ACQUIRE: begin
              if (l_ok && p_ok && lused_r[li]) begin
                if (!lheld_r[li]) begin
                  lheld_r[li] <= 1'b1;
                  lowner_r[li] <= pi;
                  if (lusers_r[li] < 5'(UsersMax)) lusers_r[li] <= lusers_r[li] + 5'd1;
                  o_st_r <= ST_DONE;
                end else if (lowner_r[li] != pi) begin
                  plink_r[pi[PW-2:0]] <= QEMPTY;
                  if (lhead_r[li] == QEMPTY) lhead_r[li] <= pi;
                  else plink_r[ltail_r[li][PW-2:0]] <= pi;
                  ltail_r[li] <= pi;
                  if (lusers_r[li] < 5'(UsersMax)) lusers_r[li] <= lusers_r[li] + 5'd1;
                  o_st_r <= ST_BLOCK;
                end
              end
            end
            FN_RELEASE, FN_WAIT: begin
              if (l_ok && p_ok && lused_r[li] && lheld_r[li] && lowner_r[li] == pi &&
                  (func_r == FN_RELEASE || (c_ok && cused_r[ci]))) begin
                if (lhead_r[li] == QEMPTY) lheld_r[li] <= 1'b0;
                else begin
                  lowner_r[li] <= lhead_r[li];
                  lhead_r[li] <= plink_r[lhead_r[li][PW-2:0]];
                  plink_r[lhead_r[li][PW-2:0]] <= QEMPTY;
                  o_wv_r <= 1'b1;
                  o_wp_r <= 4'(lhead_r[li]);
                end
                if (func_r == FN_RELEASE) begin
                  if (lusers_r[li] != 5'd0) lusers_r[li] <= lusers_r[li] - 5'd1;
                  o_st_r <= ST_DONE;
                end else begin
                  o_st_r <= ST_BLOCK;
                  state_r <= S_POP; // cvar queue push follows in S_POP
                end
              end
            end
            FN_SIGNAL, FN_BCAST: begin
              if (c_ok && cused_r[ci]) state_r <= S_POP;
            end
            FN_LRECLAIM: begin
              if (l_ok && lused_r[li] && lusers_r[li] == 5'd0) begin
                lused_r[li] <= 1'b0; lheld_r[li] <= 1'b0; o_st_r <= ST_DONE;
              end
            end
            FN_CRECLAIM: begin
              if (c_ok && cused_r[ci] && chead_r[ci] == QEMPTY) begin
                cused_r[ci] <= 1'b0; o_st_r <= ST_DONE;
              end
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          // one entry per cycle
          if (func_r == FN_LCREATE) begin
            if (scan_r == SW'(LOCKS)) state_r <= S_EMIT;
            else if (!lused_r[scan_r[LW-1:0]]) begin
              lused_r[scan_r[LW-1:0]]  <= 1'b1;
              lheld_r[scan_r[LW-1:0]]  <= 1'b0;
              lowner_r[scan_r[LW-1:0]] <= '0;
              lusers_r[scan_r[LW-1:0]] <= '0;
              lhead_r[scan_r[LW-1:0]]  <= QEMPTY;
              o_st_r <= ST_DONE; o_idx_r <= 4'(scan_r);
              state_r <= S_EMIT;
            end else scan_r <= scan_r + 1'b1;
          end else begin
            if (scan_r == SW'(CVARS)) state_r <= S_EMIT;
            else if (!cused_r[scan_r[CW-1:0]]) begin
              cused_r[scan_r[CW-1:0]] <= 1'b1;
              chead_r[scan_r[CW-1:0]] <= QEMPTY;
              o_st_r <= ST_DONE; o_idx_r <= 4'(scan_r);
              state_r <= S_EMIT;
            end else scan_r <= scan_r + 1'b1;
          end
        end
        S_POP: begin
          if (func_r == FN_WAIT) begin
            pwant_r[pi[PW-2:0]] <= li;
            plink_r[pi[PW-2:0]] <= QEMPTY;
            if (chead_r[ci] == QEMPTY) chead_r[ci] <= pi;
            else plink_r[ctail_r[ci][PW-2:0]] <= pi;
            ctail_r[ci] <= pi;
            state_r <= S_EMIT;
          end else if (chead_r[ci] == QEMPTY || cnt_r == PW'(PROCS)) begin
            // the held-back wake goes out as the final transaction
            if (woke_any_r) begin
              fin_r <= 1'b1; state_r <= S_OUT;
            end else begin
              o_st_r <= ST_DONE; state_r <= S_EMIT;
            end
          end else begin
            wproc_r <= chead_r[ci];
            chead_r[ci] <= plink_r[chead_r[ci][PW-2:0]];
            plink_r[chead_r[ci][PW-2:0]] <= QEMPTY;
            cnt_r <= cnt_r + 1'b1;
            state_r <= S_RETRY;
          end
        end
        S_RETRY: begin
          // retry the recorded lock for the popped waiter
          state_r <= (func_r == FN_SIGNAL) ? S_POP : S_POP;
          if (func_r == FN_SIGNAL) cnt_r <= PW'(PROCS);
          if (lused_r[wl]) begin
            if (!lheld_r[wl]) begin
              lheld_r[wl] <= 1'b1;
              lowner_r[wl] <= wproc_r;
              state_r <= S_OUT;
            end else if (lowner_r[wl] != wproc_r) begin
              plink_r[wsel] <= QEMPTY;
              if (lhead_r[wl] == QEMPTY) lhead_r[wl] <= wproc_r;
              else plink_r[ltail_r[wl][PW-2:0]] <= wproc_r;
              ltail_r[wl] <= wproc_r;
            end
          end
        end
        S_OUT: begin
          // each wake is held back until the next one is found, so that last can be set on the final one
          if (!woke_any_r) begin
            pend_r <= wproc_r;
            woke_any_r <= 1'b1;
            state_r <= S_POP;
          end else if (!o_valid_r || out_tready) begin
            o_st_r <= ST_DONE; o_idx_r <= '0; o_wv_r <= 1'b1; o_wp_r <= 4'(pend_r);
            o_last_r <= fin_r;
            o_valid_r <= 1'b1;
            if (fin_r) state_r <= S_IDLE;
            else begin
              pend_r <= wproc_r;
              state_r <= S_POP;
            end
          end
        end
        S_EMIT: begin
          if (!o_valid_r || out_tready) begin
            o_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_rdy_idle, clk, rst_n, in_tready, state_r == S_IDLE)
  `ASSERT_NEXT(a_accept, clk, rst_n, in_tvalid && in_tready, state_r == S_DEC)
  `ASSERT_IMPL(a_wake_ok, clk, rst_n, out_tvalid && out_tdata[6], out_tdata[1:0] != ST_ERR)
endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for lock_and_condvar_manager: directed table then random requests.
// Depends on lcm_pkg and the manager RTL; results are checked against a built-in table model.
`timescale 1ns / 1ps
module tb_top;
  import lcm_pkg::*;

  localparam int NL = 16;
  localparam int NP = 16;
  localparam logic [4:0] QNONE = 5'd16;
  localparam int WDOG = 2000;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] new_index;
    logic       wake_valid;
    logic [3:0] wake_proc;
    logic       last;
  } sync_res_t;

  typedef struct packed {
    logic [3:0] func;
    logic [3:0] lk;
    logic [3:0] cv;
    logic [3:0] proc;
    logic       chk;      // typed-in expectation present
    logic [1:0] est;
    logic [3:0] eidx;
  } dir_row_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, out_tlast;
  logic [InW-1:0] in_tdata;
  logic [OutW-1:0] out_tdata;

  lock_and_condvar_manager dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  // shadow tables
  logic       m_lused [NL];
  logic       m_lheld [NL];
  logic [3:0] m_lown  [NL];
  logic [4:0] m_lusers[NL];
  logic [4:0] m_lqh   [NL];
  logic [3:0] m_lqt   [NL];
  logic       m_cused [NL];
  logic [4:0] m_cqh   [NL];
  logic [3:0] m_cqt   [NL];
  logic [4:0] m_link  [NP];
  logic [3:0] m_want  [NP];

  sync_res_t exp_results[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic tables_reset();
    for (int i = 0; i < NL; i++) begin
      m_lused[i] = 0; m_lheld[i] = 0; m_lown[i] = 0; m_lusers[i] = 0;
      m_lqh[i] = QNONE; m_lqt[i] = 0; m_cused[i] = 0; m_cqh[i] = QNONE; m_cqt[i] = 0;
      m_link[i] = 0; m_want[i] = 0;
    end
  endtask

  function automatic sync_res_t mk(logic [1:0] st, logic [3:0] idx, logic wv,
                                   logic [3:0] wp, logic lst);
    sync_res_t r;
    r.status = st; r.new_index = idx; r.wake_valid = wv;
    r.wake_proc = wv ? wp : 4'd0; r.last = lst;
    return r;
  endfunction

  task automatic lock_q_push(int l, logic [3:0] p);
    m_link[p] = QNONE;
    if (m_lqh[l] == QNONE) m_lqh[l] = {1'b0, p};
    else m_link[m_lqt[l]] = {1'b0, p};
    m_lqt[l] = p;
  endtask

  task automatic cv_q_push(int c, logic [3:0] p);
    m_link[p] = QNONE;
    if (m_cqh[c] == QNONE) m_cqh[c] = {1'b0, p};
    else m_link[m_cqt[c]] = {1'b0, p};
    m_cqt[c] = p;
  endtask

  task automatic lock_grab(int l, logic [3:0] p, bit counted, output logic [1:0] st);
    if (!m_lused[l]) st = ST_ERR;
    else if (!m_lheld[l]) begin
      m_lheld[l] = 1; m_lown[l] = p;
      if (counted && m_lusers[l] < UsersMax) m_lusers[l]++;
      st = ST_DONE;
    end else if (m_lown[l] == p) st = ST_ERR;
    else begin
      lock_q_push(l, p);
      if (counted && m_lusers[l] < UsersMax) m_lusers[l]++;
      st = ST_BLOCK;
    end
  endtask

  // rc: -1 error, 0 freed, 1 handed over to woke
  task automatic lock_drop(int l, logic [3:0] p, bit counted, output int rc,
                           output logic [3:0] woke);
    logic [4:0] h;
    woke = 0;
    if (!m_lused[l] || !m_lheld[l] || m_lown[l] != p) begin
      rc = -1;
      return;
    end
    h = m_lqh[l];
    rc = 0;
    if (h == QNONE) m_lheld[l] = 0;
    else begin
      m_lqh[l] = m_link[h[3:0]]; m_link[h[3:0]] = QNONE;
      m_lown[l] = h[3:0]; woke = h[3:0]; rc = 1;
    end
    if (counted && m_lusers[l] > 0) m_lusers[l]--;
  endtask

  task automatic predict_request(logic [3:0] f, logic [3:0] l, logic [3:0] c, logic [3:0] p);
    logic [1:0] st;
    logic [3:0] woke;
    logic [4:0] w;
    logic [3:0] woken[$];
    int rc;
    bit found;
    found = 0;
    case (f)
      FN_LCREATE: begin
        for (int i = 0; i < NL && !found; i++) if (!m_lused[i]) begin
          m_lused[i] = 1; m_lheld[i] = 0; m_lown[i] = 0; m_lusers[i] = 0; m_lqh[i] = QNONE;
          exp_results.push_back(mk(ST_DONE, 4'(i), 0, 0, 1)); found = 1;
        end
        if (!found) exp_results.push_back(mk(ST_ERR, 0, 0, 0, 1));
      end
      FN_CCREATE: begin
        for (int i = 0; i < NL && !found; i++) if (!m_cused[i]) begin
          m_cused[i] = 1; m_cqh[i] = QNONE;
          exp_results.push_back(mk(ST_DONE, 4'(i), 0, 0, 1)); found = 1;
        end
        if (!found) exp_results.push_back(mk(ST_ERR, 0, 0, 0, 1));
      end
      FN_ACQUIRE: begin
        lock_grab(l, p, 1, st);
        exp_results.push_back(mk(st, 0, 0, 0, 1));
      end
      FN_RELEASE: begin
        lock_drop(l, p, 1, rc, woke);
        if (rc < 0) exp_results.push_back(mk(ST_ERR, 0, 0, 0, 1));
        else exp_results.push_back(mk(ST_DONE, 0, rc == 1, woke, 1));
      end
      FN_WAIT: begin
        if (!m_cused[c]) exp_results.push_back(mk(ST_ERR, 0, 0, 0, 1));
        else begin
          lock_drop(l, p, 0, rc, woke);
          if (rc < 0) exp_results.push_back(mk(ST_ERR, 0, 0, 0, 1));
          else begin
            m_want[p] = l;
            cv_q_push(c, p);
            exp_results.push_back(mk(ST_BLOCK, 0, rc == 1, woke, 1));
          end
        end
      end
      FN_SIGNAL, FN_BCAST: begin
        if (!m_cused[c]) exp_results.push_back(mk(ST_ERR, 0, 0, 0, 1));
        else begin
          for (int i = 0; i < NP; i++) begin
            w = m_cqh[c];
            if (w == QNONE) break;
            m_cqh[c] = m_link[w[3:0]]; m_link[w[3:0]] = QNONE;
            lock_grab(m_want[w[3:0]], w[3:0], 0, st);
            if (st == ST_DONE) woken.push_back(w[3:0]);
            if (f == FN_SIGNAL) break;
          end
          if (woken.size() == 0) exp_results.push_back(mk(ST_DONE, 0, 0, 0, 1));
          foreach (woken[i])
            exp_results.push_back(mk(ST_DONE, 0, 1, woken[i], i == woken.size() - 1));
        end
      end
      FN_LRECLAIM: begin
        if (!m_lused[l] || m_lusers[l] > 0) exp_results.push_back(mk(ST_ERR, 0, 0, 0, 1));
        else begin
          m_lused[l] = 0; m_lheld[l] = 0;
          exp_results.push_back(mk(ST_DONE, 0, 0, 0, 1));
        end
      end
      FN_CRECLAIM: begin
        if (!m_cused[c] || m_cqh[c] != QNONE) exp_results.push_back(mk(ST_ERR, 0, 0, 0, 1));
        else begin
          m_cused[c] = 0;
          exp_results.push_back(mk(ST_DONE, 0, 0, 0, 1));
        end
      end
      default: exp_results.push_back(mk(ST_ERR, 0, 0, 0, 1));
    endcase
  endtask

  // drive one request; returns at the edge where the transaction is accepted
  task automatic send_request(logic [3:0] f, logic [3:0] l, logic [3:0] c, logic [3:0] p);
    while (!quiet && $urandom_range(99) < 28) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {p, c, l, f};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_request(f, l, c, p);
  endtask

  // result side: random stalls, checks each accepted transaction
  always @(posedge clk) begin
    sync_res_t got, want;
    if (!rst_n) out_tready <= 0;
    else begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[1:0], out_tdata[5:2], out_tdata[6], out_tdata[10:7], out_tlast};
        if (exp_results.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, got);
          errors++;
        end else begin
          want = exp_results.pop_front();
          if (got !== want || out_tdata[15:11] !== 5'd0) begin
            $display("%0t: mismatch, expected %h actual %h (tdata %h)",
                     $time, want, got, out_tdata);
            errors++;
          end
        end
      end
      out_tready <= quiet || ($urandom_range(99) >= 28);
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // weighted random request, mostly on low indices
  task automatic random_request();
    logic [3:0] f, l, c, p;
    int r;
    r = $urandom_range(99);
    if (r < 4) f = 4'($urandom_range(15));
    else if (r < 10) f = FN_LCREATE;
    else if (r < 16) f = FN_CCREATE;
    else if (r < 36) f = FN_ACQUIRE;
    else if (r < 56) f = FN_RELEASE;
    else if (r < 70) f = FN_WAIT;
    else if (r < 80) f = FN_SIGNAL;
    else if (r < 88) f = FN_BCAST;
    else if (r < 94) f = FN_LRECLAIM;
    else f = FN_CRECLAIM;
    l = ($urandom_range(9) < 8) ? 4'($urandom_range(5)) : 4'($urandom);
    c = ($urandom_range(9) < 8) ? 4'($urandom_range(3)) : 4'($urandom);
    p = ($urandom_range(9) < 8) ? 4'($urandom_range(7)) : 4'($urandom);
    // release and wait mostly by the owner so queues drain
    if (f == FN_RELEASE || f == FN_WAIT) if (m_lheld[l] && $urandom_range(9) < 7) p = m_lown[l];
    send_request(f, l, c, p);
  endtask

  dir_row_t dir_rows[] = '{
    '{FN_ACQUIRE,  4'd0, 4'd0, 4'd0,  1'b1, ST_ERR,  4'd0},  // unused lock
    '{4'd15,       4'd15,4'd15,4'd15, 1'b1, ST_ERR,  4'd0},  // unknown func
    '{4'd9,        4'd0, 4'd0, 4'd0,  1'b1, ST_ERR,  4'd0},
    '{FN_LCREATE,  4'd0, 4'd0, 4'd0,  1'b1, ST_DONE, 4'd0},
    '{FN_LCREATE,  4'd0, 4'd0, 4'd0,  1'b1, ST_DONE, 4'd1},
    '{FN_CCREATE,  4'd0, 4'd0, 4'd0,  1'b1, ST_DONE, 4'd0},
    '{FN_ACQUIRE,  4'd0, 4'd0, 4'd3,  1'b1, ST_DONE, 4'd0},
    '{FN_ACQUIRE,  4'd0, 4'd0, 4'd3,  1'b1, ST_ERR,  4'd0},  // self re-acquire
    '{FN_ACQUIRE,  4'd0, 4'd0, 4'd15, 1'b1, ST_BLOCK,4'd0},
    '{FN_ACQUIRE,  4'd0, 4'd0, 4'd5,  1'b0, ST_DONE, 4'd0},
    '{FN_RELEASE,  4'd0, 4'd0, 4'd7,  1'b1, ST_ERR,  4'd0},  // non-owner
    '{FN_LRECLAIM, 4'd0, 4'd0, 4'd0,  1'b1, ST_ERR,  4'd0},  // busy lock
    '{FN_WAIT,     4'd0, 4'd0, 4'd3,  1'b0, ST_DONE, 4'd0},  // hands lock to 15
    '{FN_WAIT,     4'd0, 4'd0, 4'd15, 1'b0, ST_DONE, 4'd0},
    '{FN_CRECLAIM, 4'd0, 4'd0, 4'd0,  1'b1, ST_ERR,  4'd0},  // busy cvar
    '{FN_WAIT,     4'd1, 4'd0, 4'd2,  1'b1, ST_ERR,  4'd0},  // release fails
    '{FN_BCAST,    4'd0, 4'd0, 4'd0,  1'b0, ST_DONE, 4'd0},
    '{FN_SIGNAL,   4'd0, 4'd0, 4'd0,  1'b0, ST_DONE, 4'd0},  // empty queue
    '{FN_SIGNAL,   4'd0, 4'd9, 4'd0,  1'b1, ST_ERR,  4'd0},  // unused cvar
    '{FN_RELEASE,  4'd0, 4'd0, 4'd5,  1'b0, ST_DONE, 4'd0},
    '{FN_CRECLAIM, 4'd0, 4'd0, 4'd0,  1'b0, ST_DONE, 4'd0},
    '{FN_LRECLAIM, 4'd1, 4'd0, 4'd0,  1'b1, ST_DONE, 4'd0},
    '{FN_RELEASE,  4'd15,4'd0, 4'd0,  1'b1, ST_ERR,  4'd0}
  };

  initial begin
    rst_n = 0; in_tvalid = 0; in_tdata = '0;
    tables_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].func, dir_rows[i].lk, dir_rows[i].cv, dir_rows[i].proc);
      if (dir_rows[i].chk) begin
        // typed-in row overrides the predictor's entry for this request
        exp_results[exp_results.size() - 1] = mk(dir_rows[i].est, dir_rows[i].eidx, 0, 0, 1);
      end
    end
    // fill both tables to hit the full case
    for (int i = 0; i < 17; i++) send_request(FN_LCREATE, 0, 0, 0);
    for (int i = 0; i < 17; i++) send_request(FN_CCREATE, 0, 0, 0);
    for (int i = 0; i < 390; i++) begin
      quiet = (i >= 200 && i < 260);
      random_request();
    end
    in_tvalid <= 0;
    quiet = 0;
    while (exp_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && exp_results.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+design
design/lcm_pkg.sv
design/lock_and_condvar_manager.sv
tb/tb_top.sv
